### hdl/d2q9_bgk_pkg.sv
`default_nettype none

package d2q9_bgk_pkg;

  localparam int unsigned DEFAULT_DATA_WIDTH = 32;

  // Q3.28 fixed point
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned MAG_W     = 60;                 // intermediates held within +-(2^60 - 1)
  localparam int unsigned INT_W     = MAG_W + 1;          // signed intermediate
  localparam int unsigned SUM_W     = 64;                 // sums of a few intermediates
  localparam int unsigned LO_W      = 30;                 // low split of a multiplier operand
  localparam int unsigned HI_W      = INT_W - LO_W;
  localparam int unsigned PP_W      = 2 * (HI_W);
  localparam int unsigned PROD_W    = 2 * INT_W;
  localparam int unsigned Q_W       = PROD_W - FRAC_BITS;
  localparam int unsigned MUL_STAGES = 3;

  localparam logic signed [INT_W-1:0] INT_LIMIT  = (INT_W'(1) << MAG_W) - INT_W'(1);
  localparam logic signed [SUM_W-1:0] LIMIT_WIDE = (SUM_W'(1) << MAG_W) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] Q_ONE      = SUM_W'(1) << FRAC_BITS;

  // Configuration registers
  localparam int unsigned RATE_W     = 30;
  localparam int unsigned CSQ_W      = 31;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_RELAX_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INV_CSQ    = 2'd2;

  localparam logic [RATE_W-1:0] RELAX_RATE_RST = RATE_W'(268435456);
  localparam logic [RATE_W-1:0] TIME_STEP_RST  = RATE_W'(268435456);
  localparam logic [CSQ_W-1:0]  INV_CSQ_RST    = CSQ_W'(268435456);

  // Lattice directions
  localparam int unsigned DIR_W = 4;
  localparam logic [DIR_W-1:0] DIR_REST  = 4'd0;
  localparam logic [DIR_W-1:0] DIR_EAST  = 4'd1;
  localparam logic [DIR_W-1:0] DIR_NORTH = 4'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 4'd3;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 4'd4;
  localparam logic [DIR_W-1:0] DIR_NE    = 4'd5;
  localparam logic [DIR_W-1:0] DIR_NW    = 4'd6;
  localparam logic [DIR_W-1:0] DIR_SW    = 4'd7;
  localparam logic [DIR_W-1:0] DIR_SE    = 4'd8;

  localparam int unsigned WGT_W = 27;
  localparam logic [WGT_W-1:0] WGT_REST = WGT_W'(119304647);  // 4/9
  localparam logic [WGT_W-1:0] WGT_AXIS = WGT_W'(29826162);   // 1/9
  localparam logic [WGT_W-1:0] WGT_DIAG = WGT_W'(7456540);    // 1/36

  // Pipeline stage numbering
  localparam int unsigned ST_IN    = 1;
  localparam int unsigned ST_EU    = 2;
  localparam int unsigned ST_SQ    = 4;
  localparam int unsigned ST_EUC   = 5;
  localparam int unsigned ST_T1    = 6;
  localparam int unsigned ST_SQ2   = 8;
  localparam int unsigned ST_T23   = 9;
  localparam int unsigned ST_POLY  = 10;
  localparam int unsigned ST_FEQ   = 13;
  localparam int unsigned ST_DIFF  = 14;
  localparam int unsigned ST_M     = 17;
  localparam int unsigned ST_RES   = 18;
  localparam int unsigned ST_OUT   = 19;

  typedef enum logic [1:0] {
    COMP_ZERO,
    COMP_POS,
    COMP_NEG
  } comp_e;

  typedef struct packed {
    comp_e ex;
    comp_e ey;
  } lattice_vec_t;

  function automatic logic [WGT_W-1:0] weight_of(input logic [DIR_W-1:0] dir);
    unique case (dir) inside
      DIR_REST:                                  return WGT_REST;
      DIR_EAST, DIR_NORTH, DIR_WEST, DIR_SOUTH:  return WGT_AXIS;
      DIR_NE, DIR_NW, DIR_SW, DIR_SE:            return WGT_DIAG;
      default:                                   return '0;
    endcase
  endfunction

  function automatic lattice_vec_t vec_of(input logic [DIR_W-1:0] dir);
    unique case (dir)
      DIR_EAST:  return '{ex: COMP_POS,  ey: COMP_ZERO};
      DIR_NORTH: return '{ex: COMP_ZERO, ey: COMP_POS};
      DIR_WEST:  return '{ex: COMP_NEG,  ey: COMP_ZERO};
      DIR_SOUTH: return '{ex: COMP_ZERO, ey: COMP_NEG};
      DIR_NE:    return '{ex: COMP_POS,  ey: COMP_POS};
      DIR_NW:    return '{ex: COMP_NEG,  ey: COMP_POS};
      DIR_SW:    return '{ex: COMP_NEG,  ey: COMP_NEG};
      DIR_SE:    return '{ex: COMP_POS,  ey: COMP_NEG};
      default:   return '{ex: COMP_ZERO, ey: COMP_ZERO};
    endcase
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [INT_W-1:0] v);
    return SUM_W'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] eu_term(input comp_e c,
                                                      input logic signed [INT_W-1:0] u);
    case (c)
      COMP_POS: return sx(u);
      COMP_NEG: return -sx(u);
      default:  return '0;
    endcase
  endfunction

  function automatic logic sat_hit(input logic signed [SUM_W-1:0] v);
    return (v > LIMIT_WIDE) || (v < -LIMIT_WIDE);
  endfunction

  function automatic logic signed [INT_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    if (v > LIMIT_WIDE) begin
      return INT_LIMIT;
    end else if (v < -LIMIT_WIDE) begin
      return -INT_LIMIT;
    end
    return INT_W'(v);
  endfunction

endpackage

`default_nettype wire

### hdl/d2q9_bgk_mul.sv
`default_nettype none

// Three-stage Q3.28 multiplier: four 31x31 partial products, a combine with
// rounding toward zero, then saturation to +-(2^60 - 1).
module d2q9_bgk_mul
  import d2q9_bgk_pkg::*;
(
  input  logic                         clk_i,
  input  logic [MUL_STAGES-1:0]        en_i,
  input  logic signed [INT_W-1:0]      a_i,
  input  logic signed [INT_W-1:0]      b_i,
  output logic signed [INT_W-1:0]      p_o,
  output logic                         sat_o
);

  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [Q_W-1:0]    LIM_Q      = Q_W'(INT_LIMIT);

  logic signed [PP_W-1:0]   pp_d [4];
  logic signed [PP_W-1:0]   pp_q [4];
  logic                     neg_q;
  logic signed [PROD_W-1:0] sum_d;
  logic signed [Q_W-1:0]    q_d;
  logic signed [Q_W-1:0]    q_q;
  logic signed [INT_W-1:0]  p_d;
  logic                     sat_d;
  logic signed [HI_W-1:0]   a_lo;
  logic signed [HI_W-1:0]   b_lo;
  logic signed [HI_W-1:0]   a_hi;
  logic signed [HI_W-1:0]   b_hi;

  always_comb begin
    a_lo = $signed({1'b0, a_i[LO_W-1:0]});
    b_lo = $signed({1'b0, b_i[LO_W-1:0]});
    a_hi = $signed(a_i[INT_W-1:LO_W]);
    b_hi = $signed(b_i[INT_W-1:LO_W]);
    pp_d[0] = a_lo * b_lo;
    pp_d[1] = a_hi * b_lo;
    pp_d[2] = a_lo * b_hi;
    pp_d[3] = a_hi * b_hi;
  end

  // negative products get a bias so the arithmetic shift truncates toward zero
  always_comb begin
    sum_d = (PROD_W'(pp_q[3]) <<< (2 * LO_W))
          + ((PROD_W'(pp_q[1]) + PROD_W'(pp_q[2])) <<< LO_W)
          + PROD_W'(pp_q[0])
          + (neg_q ? TRUNC_BIAS : PROD_W'(0));
    q_d   = $signed(sum_d[PROD_W-1:FRAC_BITS]);
  end

  always_comb begin
    sat_d = 1'b0;
    p_d   = INT_W'(q_q);
    if (q_q > LIM_Q) begin
      sat_d = 1'b1;
      p_d   = INT_LIMIT;
    end else if (q_q < -LIM_Q) begin
      sat_d = 1'b1;
      p_d   = -INT_LIMIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_q  <= pp_d;
      neg_q <= a_i[INT_W-1] ^ b_i[INT_W-1];
    end
    if (en_i[1]) begin
      q_q <= q_d;
    end
    if (en_i[2]) begin
      p_o   <= p_d;
      sat_o <= sat_d;
    end
  end

endmodule

`default_nettype wire

### hdl/d2q9_bgk_collision_unit.sv
// D2Q9 BGK collision unit. Each transaction on the input channel carries one
// population with its direction, forcing term and node density and velocity;
// one transaction leaves on the output channel with the relaxed population
// (Q3.28, saturated to DATA_WIDTH bits) and an overflow flag that is set when
// any intermediate or the result saturated. The unit is a 19-stage pipeline
// that accepts one transaction every cycle unless it is full and the output is
// held; its depth is set by the chain of four three-stage split multipliers
// (eu*c, euc^2, rho*w*poly, rate*diff) plus the sum and saturation stages
// between them. Each stage stalls only when it and every stage after it are
// full, so bubbles are squeezed out while the output waits. The user must write
// configuration registers through the write port only while no transaction is
// in flight (not enforced by the block); they take effect on the next transaction.
`default_nettype none

module d2q9_bgk_collision_unit
  import d2q9_bgk_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [DIR_W-1:0]             direction_i,
  input  logic signed [DATA_WIDTH-1:0] population_i,
  input  logic signed [DATA_WIDTH-1:0] forcing_term_i,
  input  logic signed [DATA_WIDTH-1:0] density_i,
  input  logic signed [DATA_WIDTH-1:0] velocity_x_i,
  input  logic signed [DATA_WIDTH-1:0] velocity_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] relaxed_population_o,
  output logic                         overflow_o
);

  localparam logic signed [SUM_W:0] OUT_HI =
    ((SUM_W + 1)'(1) << (DATA_WIDTH - 1)) - (SUM_W + 1)'(1);
  localparam logic signed [SUM_W:0] OUT_LO = -OUT_HI - (SUM_W + 1)'(1);

  // configuration
  logic [RATE_W-1:0] relax_rate_q;
  logic [RATE_W-1:0] time_step_q;
  logic [CSQ_W-1:0]  inv_csq_q;

  // pipeline control
  logic [ST_OUT:ST_IN] vld_q;
  logic [ST_OUT:ST_IN] en;
  logic [ST_OUT:ST_IN] ov_q;
  logic [ST_OUT:ST_IN] ov_add;

  // stage payload
  logic signed [INT_W-1:0] f_q   [ST_IN:ST_M];
  logic signed [INT_W-1:0] tf_q  [ST_EUC:ST_M];
  logic signed [INT_W-1:0] rw_q  [ST_EUC:ST_POLY];
  logic signed [INT_W-1:0] t1_q  [ST_T1:ST_T23];
  logic signed [INT_W-1:0] frc_q;
  logic signed [INT_W-1:0] rho_q;
  logic signed [INT_W-1:0] ux_q;
  logic signed [INT_W-1:0] uy_q;
  logic [WGT_W-1:0]        wgt_q;
  lattice_vec_t            vec_q;
  logic signed [INT_W-1:0] eu_q;
  logic signed [INT_W-1:0] usq_q;
  logic signed [INT_W-1:0] t2_q;
  logic signed [INT_W-1:0] t3_q;
  logic signed [INT_W-1:0] poly_q;
  logic signed [INT_W-1:0] diff_q;
  logic signed [INT_W-1:0] res_q;
  logic signed [DATA_WIDTH-1:0] out_q;

  // multiplier results
  logic signed [INT_W-1:0] sqx_p, sqy_p, rw_p, tf_p, euc_p, sq_p, uc_p, feq_p, m_p;
  logic sqx_sat, sqy_sat, rw_sat, tf_sat, euc_sat, sq_sat, uc_sat, feq_sat, m_sat;

  // stage sums
  logic signed [SUM_W-1:0] pop_w, frc_w, rho_w, ux_w, uy_w;
  logic signed [SUM_W-1:0] eu_sum, usq_sum, t1_sum, t2_sum, t3_sum;
  logic signed [SUM_W-1:0] poly_sum, diff_sum, res_sum;
  logic signed [SUM_W+1:0] nine_sq;
  logic signed [SUM_W:0]   res_ext;
  logic signed [INT_W-1:0] csq_s, rate_s, step_s, wgt_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_rate_q <= RELAX_RATE_RST;
      time_step_q  <= TIME_STEP_RST;
      inv_csq_q    <= INV_CSQ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_RELAX_RATE: relax_rate_q <= cfg_wdata_i[RATE_W-1:0];
        CFG_TIME_STEP:  time_step_q  <= cfg_wdata_i[RATE_W-1:0];
        CFG_INV_CSQ:    inv_csq_q    <= cfg_wdata_i[CSQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign csq_s  = $signed(INT_W'(inv_csq_q));
  assign rate_s = $signed(INT_W'(relax_rate_q));
  assign step_s = $signed(INT_W'(time_step_q));
  assign wgt_s  = $signed(INT_W'(wgt_q));

  // a stage moves when the output is taken or a bubble sits at or after it
  always_comb begin
    for (int s = ST_IN; s <= ST_OUT; s++) begin
      en[s] = out_ready_i || ((~vld_q >> (s - ST_IN)) != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[ST_IN]) begin
        vld_q[ST_IN] <= in_valid_i;
      end
      for (int s = ST_IN + 1; s <= ST_OUT; s++) begin
        if (en[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign in_ready_o           = en[ST_IN];
  assign out_valid_o          = vld_q[ST_OUT];
  assign relaxed_population_o = out_q;
  assign overflow_o           = ov_q[ST_OUT];

  d2q9_bgk_mul u_mul_sqx (
    .clk_i, .en_i(en[ST_SQ:ST_IN+1]), .a_i(ux_q), .b_i(ux_q), .p_o(sqx_p), .sat_o(sqx_sat)
  );
  d2q9_bgk_mul u_mul_sqy (
    .clk_i, .en_i(en[ST_SQ:ST_IN+1]), .a_i(uy_q), .b_i(uy_q), .p_o(sqy_p), .sat_o(sqy_sat)
  );
  d2q9_bgk_mul u_mul_rw (
    .clk_i, .en_i(en[ST_SQ:ST_IN+1]), .a_i(rho_q), .b_i(wgt_s), .p_o(rw_p), .sat_o(rw_sat)
  );
  d2q9_bgk_mul u_mul_tf (
    .clk_i, .en_i(en[ST_SQ:ST_IN+1]), .a_i(step_s), .b_i(frc_q), .p_o(tf_p), .sat_o(tf_sat)
  );
  d2q9_bgk_mul u_mul_euc (
    .clk_i, .en_i(en[ST_EUC:ST_EU+1]), .a_i(eu_q), .b_i(csq_s), .p_o(euc_p), .sat_o(euc_sat)
  );
  d2q9_bgk_mul u_mul_sq (
    .clk_i, .en_i(en[ST_SQ2:ST_EUC+1]), .a_i(euc_p), .b_i(euc_p), .p_o(sq_p), .sat_o(sq_sat)
  );
  d2q9_bgk_mul u_mul_uc (
    .clk_i, .en_i(en[ST_SQ2:ST_EUC+1]), .a_i(usq_q), .b_i(csq_s), .p_o(uc_p), .sat_o(uc_sat)
  );
  d2q9_bgk_mul u_mul_feq (
    .clk_i, .en_i(en[ST_FEQ:ST_POLY+1]), .a_i(rw_q[ST_POLY]), .b_i(poly_q), .p_o(feq_p),
    .sat_o(feq_sat)
  );
  d2q9_bgk_mul u_mul_m (
    .clk_i, .en_i(en[ST_M:ST_DIFF+1]), .a_i(rate_s), .b_i(diff_q), .p_o(m_p), .sat_o(m_sat)
  );

  always_comb begin
    pop_w    = SUM_W'(population_i);
    frc_w    = SUM_W'(forcing_term_i);
    rho_w    = SUM_W'(density_i);
    ux_w     = SUM_W'(velocity_x_i);
    uy_w     = SUM_W'(velocity_y_i);
    eu_sum   = eu_term(vec_q.ex, ux_q) + eu_term(vec_q.ey, uy_q);
    usq_sum  = sx(sqx_p) + sx(sqy_p);
    t1_sum   = sx(euc_p) + (sx(euc_p) <<< 1);
    // both squares are non-negative, so the halving shift truncates toward zero
    nine_sq  = ((SUM_W + 2)'(sq_p) <<< 3) + (SUM_W + 2)'(sq_p);
    t2_sum   = SUM_W'(nine_sq >>> 1);
    t3_sum   = (sx(uc_p) + (sx(uc_p) <<< 1)) >>> 1;
    poly_sum = Q_ONE + sx(t1_q[ST_T23]) + sx(t2_q) - sx(t3_q);
    diff_sum = sx(f_q[ST_FEQ]) - sx(feq_p);
    res_sum  = sx(f_q[ST_M]) - sx(m_p) + sx(tf_q[ST_M]);
    res_ext  = (SUM_W + 1)'(res_q);
  end

  always_comb begin
    ov_add          = '0;
    ov_add[ST_IN]   = sat_hit(pop_w) | sat_hit(frc_w) | sat_hit(rho_w)
                    | sat_hit(ux_w) | sat_hit(uy_w);
    ov_add[ST_EU]   = sat_hit(eu_sum);
    ov_add[ST_EUC]  = sqx_sat | sqy_sat | rw_sat | tf_sat | sat_hit(usq_sum);
    ov_add[ST_T1]   = euc_sat | sat_hit(t1_sum);
    ov_add[ST_T23]  = sq_sat | uc_sat | sat_hit(t2_sum) | sat_hit(t3_sum);
    ov_add[ST_POLY] = sat_hit(poly_sum);
    ov_add[ST_DIFF] = feq_sat | sat_hit(diff_sum);
    ov_add[ST_RES]  = m_sat | sat_hit(res_sum);
    ov_add[ST_OUT]  = (res_ext > OUT_HI) || (res_ext < OUT_LO);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      f_q[ST_IN]  <= sat_val(pop_w);
      frc_q       <= sat_val(frc_w);
      rho_q       <= sat_val(rho_w);
      ux_q        <= sat_val(ux_w);
      uy_q        <= sat_val(uy_w);
      wgt_q       <= weight_of(direction_i);
      vec_q       <= vec_of(direction_i);
      ov_q[ST_IN] <= ov_add[ST_IN];
    end
    for (int s = ST_IN + 1; s <= ST_OUT; s++) begin
      if (en[s]) begin
        ov_q[s] <= ov_q[s-1] | ov_add[s];
      end
    end
    for (int s = ST_IN + 1; s <= ST_M; s++) begin
      if (en[s]) begin
        f_q[s] <= f_q[s-1];
      end
    end
    if (en[ST_EU]) begin
      eu_q <= sat_val(eu_sum);
    end
    if (en[ST_EUC]) begin
      usq_q        <= sat_val(usq_sum);
      rw_q[ST_EUC] <= rw_p;
      tf_q[ST_EUC] <= tf_p;
    end
    for (int s = ST_EUC + 1; s <= ST_M; s++) begin
      if (en[s]) begin
        tf_q[s] <= tf_q[s-1];
      end
    end
    for (int s = ST_EUC + 1; s <= ST_POLY; s++) begin
      if (en[s]) begin
        rw_q[s] <= rw_q[s-1];
      end
    end
    if (en[ST_T1]) begin
      t1_q[ST_T1] <= sat_val(t1_sum);
    end
    for (int s = ST_T1 + 1; s <= ST_T23; s++) begin
      if (en[s]) begin
        t1_q[s] <= t1_q[s-1];
      end
    end
    if (en[ST_T23]) begin
      t2_q <= sat_val(t2_sum);
      t3_q <= sat_val(t3_sum);
    end
    if (en[ST_POLY]) begin
      poly_q <= sat_val(poly_sum);
    end
    if (en[ST_DIFF]) begin
      diff_q <= sat_val(diff_sum);
    end
    if (en[ST_RES]) begin
      res_q <= sat_val(res_sum);
    end
    if (en[ST_OUT]) begin
      if (res_ext > OUT_HI) begin
        out_q <= OUT_HI[DATA_WIDTH-1:0];
      end else if (res_ext < OUT_LO) begin
        out_q <= OUT_LO[DATA_WIDTH-1:0];
      end else begin
        out_q <= res_ext[DATA_WIDTH-1:0];
      end
    end
  end

  // input is refused only when every stage holds a transaction and the output is held
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("input refused while the pipeline has a free stage");

  // transactions in flight change only by what enters and what leaves
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q))
      + $past(in_valid_i && in_ready_o) - $past(out_valid_o && out_ready_i)))
    else $error("transaction lost or duplicated in the pipeline");

  a_cfg_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_addr_i == CFG_RELAX_RATE) |=>
      (relax_rate_q == $past(cfg_wdata_i[RATE_W-1:0]) && $stable(time_step_q)
       && $stable(inv_csq_q)))
    else $error("relax rate write not applied cleanly");

endmodule

`default_nettype wire
